// ----- design/crd_pkg.sv -----
// Shared types, codes and the name table of the character reference decoder.
`default_nettype none
package crd_pkg;

	localparam int unsigned NAME_COUNT_DEF   = 4;
	localparam int unsigned MAX_NAME_LEN_DEF = 4;
	localparam int unsigned TABLE_ROWS       = 4;
	localparam int unsigned TABLE_COLS       = 4;
	localparam int unsigned ROW_W            = $clog2(TABLE_ROWS);
	localparam int unsigned COL_W            = $clog2(TABLE_COLS);
	localparam int unsigned VALUE_W          = 31;

	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_A_LO  = 8'h61;
	localparam logic [7:0] CH_F_LO  = 8'h66;
	localparam logic [7:0] CH_A_UP  = 8'h41;
	localparam logic [7:0] CH_F_UP  = 8'h46;

	// Sorted name table, zero padded
	localparam logic [7:0] NAME_TEXT [TABLE_ROWS][TABLE_COLS] = '{
		'{8'h61, 8'h6D, 8'h70, 8'h00},
		'{8'h67, 8'h74, 8'h00, 8'h00},
		'{8'h6C, 8'h74, 8'h00, 8'h00},
		'{8'h71, 8'h75, 8'h6F, 8'h74}
	};
	localparam logic [VALUE_W-1:0] NAME_VALUE [TABLE_ROWS] = '{
		31'h26, 31'h3E, 31'h3C, 31'h22
	};

	typedef enum logic [1:0] {
		ST_CONTINUE   = 2'd0,
		ST_DETERMINED = 2'd1,
		ST_INVALID    = 2'd2
	} status_t;

	typedef enum logic [6:0] {
		MODE_START = 7'b0000001,
		MODE_AMP   = 7'b0000010,
		MODE_HASH  = 7'b0000100,
		MODE_DEC   = 7'b0001000,
		MODE_HEX   = 7'b0010000,
		MODE_NAMED = 7'b0100000,
		MODE_DONE  = 7'b1000000
	} mode_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] char_byte;
	} in_item_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] code_value;
	} out_item_t;

	// Flags from the name matcher to the decoder
	typedef struct packed {
		logic hit;
		logic end_cur;
		logic end_new;
	} match_t;

	function automatic logic [7:0] name_char(input int unsigned row, input int unsigned pos,
						 input int unsigned count, input int unsigned len);
		if (row >= TABLE_ROWS || row >= count || pos >= TABLE_COLS || pos >= len)
			return 8'h00;
		return NAME_TEXT[row[ROW_W-1:0]][pos[COL_W-1:0]];
	endfunction

	function automatic logic [VALUE_W-1:0] name_val(input int unsigned row,
							input int unsigned count);
		if (row >= TABLE_ROWS || row >= count)
			return '0;
		return NAME_VALUE[row[ROW_W-1:0]];
	endfunction

endpackage
`default_nettype wire

// ----- design/char_reference_decoder_core.sv -----
// Top level of the character reference decoder: input and result registers.
//
// Usage: feed one byte per transfer on the byte channel (byte_valid, byte_stall,
// byte_item). kind = 1 restarts decoding of a new reference; kind = 0 carries a
// character byte. Every byte transfer yields exactly one transfer on the result
// channel (res_valid, res_stall, res_item): status continue, determined or
// invalid, and code_value holding the decoded character number once the
// reference is determined, else all ones.
// Path: a byte accepted into the input register is decoded combinationally and
// its result is loaded into the result register when the input register advances.
// Throughput: one byte per cycle unless res_stall holds the result register,
// set by the combinational decode between the input register and the result
// register; decoder state updates as each result is loaded.
// Stall: while the result register holds an untaken result and res_stall is high,
// the input register holds its byte and byte_stall rises; nothing is dropped.
// Reset: arst_n clears both registers and returns the decoder to its start mode,
// awaiting an ampersand, with the name range covering the whole table.
`default_nettype none
module char_reference_decoder_core #(
	parameter int unsigned NAME_COUNT   = crd_pkg::NAME_COUNT_DEF,
	parameter int unsigned MAX_NAME_LEN = crd_pkg::MAX_NAME_LEN_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              byte_valid,
	output logic                   byte_stall,
	input  wire crd_pkg::in_item_t byte_item,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output crd_pkg::out_item_t     res_item
);
	import crd_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t res_s2;
	out_item_t res_d;
	logic      adv;

	assign adv        = valid_s1 && (!valid_s2 || !res_stall);
	assign byte_stall = valid_s1 && !adv;

	crd_decode #(
		.NAME_COUNT  (NAME_COUNT),
		.MAX_NAME_LEN(MAX_NAME_LEN)
	) u_decode (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (adv),
		.item  (item_s1),
		.res   (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall)
			item_s1 <= byte_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!res_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res_d;
	end

	assign res_valid = valid_s2;
	assign res_item  = res_s2;

`ifndef SYNTH
	a_det_value_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_item.status == ST_DETERMINED) |-> !res_item.code_value[31])
		else $error("determined result with negative code value");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_item.status != 2'd3))
		else $error("result status outside defined codes");

	a_res_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1))
		else $error("result appeared without a byte in the input register");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |=> valid_s1)
		else $error("input register lost a stalled byte");
`endif

endmodule
`default_nettype wire

// ----- design/crd_name_match.sv -----
// Parallel name table compare: narrows the candidate range by one byte.
`default_nettype none
module crd_name_match #(
	parameter int unsigned NAME_COUNT   = 4,
	parameter int unsigned MAX_NAME_LEN = 4,
	parameter int unsigned RF_W         = 2,
	parameter int unsigned RL_W         = 3,
	parameter int unsigned POS_W        = 3
) (
	input  wire logic [RF_W-1:0]  range_first,
	input  wire logic [RL_W-1:0]  range_limit,
	input  wire logic [POS_W-1:0] position,
	input  wire logic [7:0]       ch,
	output crd_pkg::match_t       flags,
	output logic [RF_W-1:0]       first_next,
	output logic [RL_W-1:0]       limit_next
);
	import crd_pkg::*;

	logic [NAME_COUNT-1:0] m;
	logic                  hit;
	logic                  stop;

	always_comb begin
		for (int i = 0; i < NAME_COUNT; i++) begin
			m[i] = (i >= int'(range_first)) && (i < int'(range_limit)) &&
			       (name_char(i, 32'(position), NAME_COUNT, MAX_NAME_LEN) == ch);
		end
	end

	// First matching row opens the new range, first later mismatch closes it
	always_comb begin
		hit        = 1'b0;
		stop       = 1'b0;
		first_next = '0;
		limit_next = range_limit;
		for (int i = 0; i < NAME_COUNT; i++) begin
			if (m[i] && !hit) begin
				hit        = 1'b1;
				first_next = RF_W'(i);
			end else if (hit && !stop && !m[i] && (i < int'(range_limit))) begin
				limit_next = RL_W'(i);
				stop       = 1'b1;
			end
		end
	end

	assign flags.hit     = hit;
	assign flags.end_cur = (name_char(32'(range_first), 32'(position),
					  NAME_COUNT, MAX_NAME_LEN) == 8'h00);
	assign flags.end_new = (name_char(32'(first_next), 32'(position),
					  NAME_COUNT, MAX_NAME_LEN) == 8'h00);

endmodule
`default_nettype wire

// ----- design/crd_decode.sv -----
// Decoder state and per-byte next-state logic.
`default_nettype none
module crd_decode #(
	parameter int unsigned NAME_COUNT   = 4,
	parameter int unsigned MAX_NAME_LEN = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire crd_pkg::in_item_t item,
	output crd_pkg::out_item_t     res
);
	import crd_pkg::*;

	localparam int unsigned RF_W  = (NAME_COUNT > 1) ? $clog2(NAME_COUNT) : 1;
	localparam int unsigned RL_W  = $clog2(NAME_COUNT + 1);
	localparam int unsigned POS_W = $clog2(MAX_NAME_LEN + 1);

	mode_t              mode_q, mode_d;
	logic [VALUE_W-1:0] acc_q, acc_d;
	logic [RF_W-1:0]    rf_q, rf_d, rf_m;
	logic [RL_W-1:0]    rl_q, rl_d, rl_m;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic               nm_q, nm_d;
	logic               term_q, term_d;
	match_t             mf;
	status_t            st, named_st;
	logic [7:0]         c;
	logic               dig;
	logic               hex_lo;
	logic               hex_up;

	function automatic logic [VALUE_W-1:0] acc_step(input logic [VALUE_W-1:0] v,
							input logic hex, input logic [3:0] d);
		logic [VALUE_W+4:0] s;
		if (hex)
			s = {1'b0, v, 4'b0} + (VALUE_W+5)'(d);
		else
			s = {2'b0, v, 3'b0} + {4'b0, v, 1'b0} + (VALUE_W+5)'(d);
		// saturate at the largest positive value
		return (s[VALUE_W+4:VALUE_W] != '0) ? '1 : s[VALUE_W-1:0];
	endfunction

	crd_name_match #(
		.NAME_COUNT  (NAME_COUNT),
		.MAX_NAME_LEN(MAX_NAME_LEN),
		.RF_W        (RF_W),
		.RL_W        (RL_W),
		.POS_W       (POS_W)
	) u_match (
		.range_first(rf_q),
		.range_limit(rl_q),
		.position   (pos_q),
		.ch         (c),
		.flags      (mf),
		.first_next (rf_m),
		.limit_next (rl_m)
	);

	assign c      = item.char_byte;
	assign dig    = (c >= CH_ZERO) && (c <= CH_NINE);
	assign hex_lo = (c >= CH_A_LO) && (c <= CH_F_LO);
	assign hex_up = (c >= CH_A_UP) && (c <= CH_F_UP);

	always_comb begin
		mode_d   = mode_q;
		acc_d    = acc_q;
		rf_d     = rf_q;
		rl_d     = rl_q;
		pos_d    = pos_q;
		nm_d     = nm_q;
		term_d   = term_q;
		st       = ST_INVALID;
		named_st = ST_INVALID;

		// name matcher step, taken only in the ampersand and named modes
		priority if (term_q) begin
			named_st = ST_INVALID;
		end else if (c == CH_SEMI) begin
			named_st = ST_INVALID;
		end else if (nm_q) begin
			named_st = ST_INVALID;
		end else if (!mf.hit) begin
			named_st = ST_INVALID;
		end else if (mf.end_new) begin
			named_st = ST_INVALID;
		end else begin
			named_st = ST_CONTINUE;
		end

		if (item.kind) begin
			mode_d = MODE_START;
			acc_d  = '0;
			rf_d   = '0;
			rl_d   = RL_W'(NAME_COUNT);
			pos_d  = '0;
			nm_d   = 1'b0;
			term_d = 1'b0;
			st     = ST_CONTINUE;
		end else begin
			unique case (mode_q)
				MODE_START: begin
					if (c == CH_AMP) begin
						mode_d = MODE_AMP;
						st     = ST_CONTINUE;
					end
				end
				MODE_AMP, MODE_NAMED: begin
					if (mode_q == MODE_AMP && c == CH_HASH) begin
						mode_d = MODE_HASH;
						st     = ST_CONTINUE;
					end else if (mode_q == MODE_NAMED || c != CH_SEMI) begin
						mode_d = MODE_NAMED;
						st     = named_st;
						priority if (term_q) begin
						end else if (c == CH_SEMI) begin
							term_d = 1'b1;
							if (!nm_q && mf.end_cur) begin
								acc_d  = name_val(32'(rf_q), NAME_COUNT);
								st     = ST_DETERMINED;
								mode_d = MODE_DONE;
							end
						end else if (nm_q) begin
						end else if (!mf.hit) begin
							nm_d = 1'b1;
						end else begin
							rf_d = rf_m;
							rl_d = rl_m;
							if (mf.end_new)
								nm_d = 1'b1;
							else
								pos_d = pos_q + 1'b1;
						end
					end
				end
				MODE_HASH: begin
					if (c == CH_X_LO || c == CH_X_UP) begin
						mode_d = MODE_HEX;
						st     = ST_CONTINUE;
					end else if (dig) begin
						mode_d = MODE_DEC;
						acc_d  = VALUE_W'(c[3:0]);
						st     = ST_CONTINUE;
					end
				end
				MODE_DEC: begin
					if (dig) begin
						acc_d = acc_step(acc_q, 1'b0, c[3:0]);
						st    = ST_CONTINUE;
					end else if (c == CH_SEMI) begin
						mode_d = MODE_DONE;
						st     = ST_DETERMINED;
					end
				end
				MODE_HEX: begin
					if (dig) begin
						acc_d = acc_step(acc_q, 1'b1, c[3:0]);
						st    = ST_CONTINUE;
					end else if (hex_lo || hex_up) begin
						// letters a-f and A-F share low bits 1..6
						acc_d = acc_step(acc_q, 1'b1, c[3:0] + 4'd9);
						st    = ST_CONTINUE;
					end else if (c == CH_SEMI) begin
						mode_d = MODE_DONE;
						st     = ST_DETERMINED;
					end
				end
				default: begin
					st = ST_INVALID;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_START;
			acc_q  <= '0;
			rf_q   <= '0;
			rl_q   <= RL_W'(NAME_COUNT);
			pos_q  <= '0;
			nm_q   <= 1'b0;
			term_q <= 1'b0;
		end else if (en) begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			rf_q   <= rf_d;
			rl_q   <= rl_d;
			pos_q  <= pos_d;
			nm_q   <= nm_d;
			term_q <= term_d;
		end
	end

	assign res.status     = st;
	assign res.code_value = (mode_d == MODE_DONE) ? $signed({1'b0, acc_d}) : -32'sd1;

endmodule
`default_nettype wire

// ----- test/char_reference_decoder_core_tb.sv -----
// Testbench for char_reference_decoder_core: directed table, random references, random stalls.
module char_reference_decoder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import crd_pkg::*;

	localparam int unsigned DIR_N       = 28;
	localparam int unsigned RAND_ITEMS  = 1550;
	localparam int unsigned QUIET_LIMIT = 3000;
	localparam int unsigned LONG_HOLD   = 400;

	// One row of the directed table; known marks rows whose result is typed in
	typedef struct packed {
		logic               kind;
		logic [7:0]         ch;
		logic               known;
		status_t            st;
		logic signed [31:0] val;
	} dir_row_t;

	localparam dir_row_t DIR_TAB [DIR_N] = '{
		'{1'b1, 8'hFF,   1'b1, ST_CONTINUE,   -32'sd1},
		'{1'b0, 8'h00,   1'b1, ST_INVALID,    -32'sd1},
		'{1'b0, 8'hFF,   1'b1, ST_INVALID,    -32'sd1},
		'{1'b0, CH_AMP,  1'b1, ST_CONTINUE,   -32'sd1},
		'{1'b0, CH_SEMI, 1'b1, ST_INVALID,    -32'sd1},
		'{1'b0, CH_HASH, 1'b0, ST_CONTINUE,   32'sd0},
		'{1'b0, CH_X_UP, 1'b0, ST_CONTINUE,   32'sd0},
		'{1'b0, CH_F_UP, 1'b0, ST_CONTINUE,   32'sd0},
		'{1'b0, "G",     1'b0, ST_CONTINUE,   32'sd0},
		'{1'b0, CH_SEMI, 1'b1, ST_DETERMINED, 32'sd15},
		'{1'b0, "1",     1'b1, ST_INVALID,    32'sd15},
		'{1'b1, 8'h00,   1'b1, ST_CONTINUE,   -32'sd1},
		'{1'b0, CH_AMP,  1'b0, ST_CONTINUE,   32'sd0},
		'{1'b0, "g",     1'b0, ST_CONTINUE,   32'sd0},
		'{1'b0, "t",     1'b0, ST_CONTINUE,   32'sd0},
		'{1'b0, 8'h00,   1'b0, ST_CONTINUE,   32'sd0},
		'{1'b0, CH_SEMI, 1'b0, ST_CONTINUE,   32'sd0},
		'{1'b0, CH_SEMI, 1'b0, ST_CONTINUE,   32'sd0},
		'{1'b1, 8'h5A,   1'b1, ST_CONTINUE,   -32'sd1},
		'{1'b0, CH_AMP,  1'b0, ST_CONTINUE,   32'sd0},
		'{1'b0, "q",     1'b0, ST_CONTINUE,   32'sd0},
		'{1'b0, "x",     1'b0, ST_CONTINUE,   32'sd0},
		'{1'b0, CH_SEMI, 1'b0, ST_CONTINUE,   32'sd0},
		'{1'b1, 8'hA5,   1'b1, ST_CONTINUE,   -32'sd1},
		'{1'b0, CH_AMP,  1'b0, ST_CONTINUE,   32'sd0},
		'{1'b0, "l",     1'b0, ST_CONTINUE,   32'sd0},
		'{1'b0, "t",     1'b0, ST_CONTINUE,   32'sd0},
		'{1'b0, CH_SEMI, 1'b1, ST_DETERMINED, 32'sd60}
	};

	logic      clk        = 1'b0;
	logic      arst_n     = 1'b0;
	logic      byte_valid = 1'b0;
	in_item_t  byte_item  = '0;
	logic      res_stall  = 1'b0;
	logic      byte_stall;
	logic      res_valid;
	out_item_t res_item;

	char_reference_decoder_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_item   (res_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Decoder state mirrored at the block's widths, the accumulator one bit wider
	mode_t       dec_mode;
	logic [31:0] dec_acc;
	logic [1:0]  rng_first;
	logic [2:0]  rng_limit;
	logic [2:0]  name_pos;
	logic        miss_seen;
	logic        term_seen;

	in_item_t    byte_q [$];
	out_item_t   decode_q [$];
	string       name_list [4] = '{"amp", "gt", "lt", "quot"};

	int unsigned byte_seen = 0;
	int unsigned res_seen  = 0;
	int unsigned det_seen  = 0;
	int unsigned sat_seen  = 0;
	int unsigned fail_cnt  = 0;
	int unsigned quiet_cyc = 0;
	bit          long_hold_done = 1'b0;

	function automatic void clear_decoder();
		dec_mode  = MODE_START;
		dec_acc   = '0;
		rng_first = '0;
		rng_limit = 3'(NAME_COUNT_DEF);
		name_pos  = '0;
		miss_seen = 1'b0;
		term_seen = 1'b0;
	endfunction

	// Table byte, zero past the end of a name or outside the table
	function automatic logic [7:0] name_at(int unsigned row, int unsigned pos);
		if (row >= TABLE_ROWS || row >= NAME_COUNT_DEF)
			return 8'h00;
		if (pos >= TABLE_COLS || pos >= MAX_NAME_LEN_DEF)
			return 8'h00;
		return NAME_TEXT[row][pos];
	endfunction

	function automatic void add_digit(int unsigned base, int unsigned d);
		logic [63:0] v;
		v = {32'b0, dec_acc} * base + d;
		dec_acc = (v > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : v[31:0];
	endfunction

	// Narrow the name range by one byte
	function automatic status_t name_step(logic [7:0] c);
		int unsigned i;
		int unsigned j;
		if (term_seen)
			return ST_INVALID;
		if (c == CH_SEMI) begin
			term_seen = 1'b1;
			if (miss_seen)
				return ST_INVALID;
			if (name_at(32'(rng_first), 32'(name_pos)) == 8'h00) begin
				dec_acc = {1'b0, NAME_VALUE[rng_first]};
				return ST_DETERMINED;
			end
			return ST_INVALID;
		end
		if (miss_seen)
			return ST_INVALID;
		i = 32'(rng_first);
		while (i < rng_limit && name_at(i, 32'(name_pos)) != c)
			i++;
		if (i >= rng_limit) begin
			miss_seen = 1'b1;
			return ST_INVALID;
		end
		rng_first = i[1:0];
		j = i + 1;
		while (j < rng_limit && name_at(j, 32'(name_pos)) == c)
			j++;
		rng_limit = j[2:0];
		// a zero byte lands here: it matches only the padding past a name
		if (name_at(32'(rng_first), 32'(name_pos)) == 8'h00) begin
			miss_seen = 1'b1;
			return ST_INVALID;
		end
		name_pos++;
		return ST_CONTINUE;
	endfunction

	function automatic out_item_t decode_byte(in_item_t it);
		out_item_t  r;
		status_t    st;
		logic [7:0] c;
		logic       dig;
		c   = it.char_byte;
		dig = (c >= CH_ZERO && c <= CH_NINE);
		st  = ST_INVALID;
		if (it.kind) begin
			clear_decoder();
			st = ST_CONTINUE;
		end else begin
			case (dec_mode)
			MODE_START: begin
				if (c == CH_AMP) begin
					dec_mode = MODE_AMP;
					st = ST_CONTINUE;
				end
			end
			MODE_AMP: begin
				if (c == CH_HASH) begin
					dec_mode = MODE_HASH;
					st = ST_CONTINUE;
				end else if (c != CH_SEMI) begin
					// first name byte enters named mode even when it fails
					dec_mode = MODE_NAMED;
					st = name_step(c);
					if (st != ST_CONTINUE)
						st = ST_INVALID;
				end
			end
			MODE_HASH: begin
				if (c == CH_X_LO || c == CH_X_UP) begin
					dec_mode = MODE_HEX;
					st = ST_CONTINUE;
				end else if (dig) begin
					dec_mode = MODE_DEC;
					dec_acc = 32'(c - CH_ZERO);
					st = ST_CONTINUE;
				end
			end
			MODE_DEC: begin
				if (dig) begin
					add_digit(10, 32'(c - CH_ZERO));
					st = ST_CONTINUE;
				end else if (c == CH_SEMI) begin
					dec_mode = MODE_DONE;
					st = ST_DETERMINED;
				end
			end
			MODE_HEX: begin
				if (dig) begin
					add_digit(16, 32'(c - CH_ZERO));
					st = ST_CONTINUE;
				end else if (c >= CH_A_LO && c <= CH_F_LO) begin
					add_digit(16, c - CH_A_LO + 10);
					st = ST_CONTINUE;
				end else if (c >= CH_A_UP && c <= CH_F_UP) begin
					add_digit(16, c - CH_A_UP + 10);
					st = ST_CONTINUE;
				end else if (c == CH_SEMI) begin
					dec_mode = MODE_DONE;
					st = ST_DETERMINED;
				end
			end
			MODE_NAMED: begin
				st = name_step(c);
				if (st == ST_DETERMINED)
					dec_mode = MODE_DONE;
			end
			default: begin
				st = ST_INVALID;
			end
			endcase
		end
		r.status     = st;
		r.code_value = (dec_mode == MODE_DONE) ? dec_acc : '1;
		return r;
	endfunction

	function automatic logic [7:0] rand_byte();
		logic [31:0] r;
		r = $urandom;
		return r[7:0];
	endfunction

	task automatic put(logic k, logic [7:0] b);
		in_item_t it;
		it.kind      = k;
		it.char_byte = b;
		byte_q.push_back(it);
	endtask

	// Corrupt a byte of an otherwise well-formed reference now and then
	task automatic put_body(logic [7:0] b);
		if ($urandom_range(0, 39) == 0)
			put(1'b0, rand_byte());
		else
			put(1'b0, b);
	endtask

	task automatic gen_reference();
		int unsigned r;
		int unsigned n;
		int unsigned k;
		int unsigned v;
		int unsigned cut;
		int unsigned p;
		logic [7:0]  odd;
		string       nm;
		if ($urandom_range(0, 9) != 0)
			put(1'b1, rand_byte());
		r = $urandom_range(0, 99);
		if (r < 12) begin
			n = $urandom_range(1, 6);
			repeat (n) put($urandom_range(0, 19) == 0, rand_byte());
		end else if (r < 37) begin
			put_body(CH_AMP);
			put_body(CH_HASH);
			n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 4);
			repeat (n) begin
				v = $urandom_range(0, 9);
				put_body(CH_ZERO + v[7:0]);
			end
			put_body(CH_SEMI);
		end else if (r < 62) begin
			put_body(CH_AMP);
			put_body(CH_HASH);
			put_body($urandom_range(0, 1) ? CH_X_UP : CH_X_LO);
			n = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 11) : $urandom_range(1, 4);
			repeat (n) begin
				v = $urandom_range(0, 15);
				if (v < 10)
					put_body(CH_ZERO + v[7:0]);
				else if ($urandom_range(0, 1))
					put_body(CH_A_LO + v[7:0] - 8'd10);
				else
					put_body(CH_A_UP + v[7:0] - 8'd10);
			end
			put_body(CH_SEMI);
		end else if (r < 88) begin
			nm = name_list[$urandom_range(0, 3)];
			v  = $urandom_range(0, 25);
			case ($urandom_range(0, 3))
			0: odd = 8'h00;
			1: odd = CH_A_LO + v[7:0];
			2: odd = CH_SEMI;
			default: odd = rand_byte();
			endcase
			put_body(CH_AMP);
			k   = $urandom_range(0, 9);
			cut = (k == 6 || k == 7) ? $urandom_range(0, nm.len() - 1) : nm.len();
			for (p = 0; p < cut; p++)
				put_body(nm[p]);
			// truncated name with a stray byte, or a byte past the end of the name
			if (k >= 6 && k <= 8)
				put_body(odd);
			put_body(CH_SEMI);
			if (k == 9)
				put_body(name_list[$urandom_range(0, 3)][0]);
		end else begin
			put_body(CH_AMP);
			n = $urandom_range(1, 4);
			repeat (n) begin
				case ($urandom_range(0, 9))
				0: odd = CH_SEMI;
				1: odd = CH_HASH;
				2: odd = CH_X_LO;
				3: odd = CH_X_UP;
				4: odd = CH_ZERO;
				5: odd = CH_NINE;
				6: odd = CH_A_LO;
				7: odd = CH_F_UP;
				8: odd = CH_AMP;
				default: odd = rand_byte();
				endcase
				put_body(odd);
			end
		end
		if ($urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 3);
			repeat (n) put(1'b0, rand_byte());
		end
	endtask

	initial clear_decoder();

	// Check each result transfer, then predict each byte transfer
	always @(posedge clk) begin : mon
		out_item_t want;
		out_item_t got;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				got = res_item;
				res_seen++;
				if (got.status == ST_DETERMINED) begin
					det_seen++;
					if (got.code_value == 32'sh7FFF_FFFF)
						sat_seen++;
				end
				if (decode_q.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("%0t: result %0d unexpected: status %0d code %0d",
							$realtime, res_seen, got.status, got.code_value);
				end else begin
					want = decode_q.pop_front();
					if (got.status !== want.status || got.code_value !== want.code_value) begin
						fail_cnt++;
						if (fail_cnt <= 10)
							$display("%0t: result %0d expected %0d/%0d, got %0d/%0d",
								$realtime, res_seen, want.status, want.code_value,
								got.status, got.code_value);
					end
				end
			end
			if (byte_valid && !byte_stall) begin
				want = decode_byte(byte_item);
				if (byte_seen < DIR_N && DIR_TAB[byte_seen].known) begin
					want.status     = DIR_TAB[byte_seen].st;
					want.code_value = DIR_TAB[byte_seen].val;
				end
				decode_q.push_back(want);
				byte_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_valid && !byte_stall) || (res_valid && !res_stall))
				quiet_cyc = 0;
			else
				quiet_cyc++;
			if (quiet_cyc >= QUIET_LIMIT) begin
				$display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
					QUIET_LIMIT, decode_q.size());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Result side: random stalls, quiet stretches and one long hold-off
	initial begin : rx
		int unsigned r;
		int unsigned hold_len;
		int unsigned open_len;
		while (arst_n !== 1'b1)
			@(posedge clk);
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (!long_hold_done && res_seen >= 700) begin
				long_hold_done = 1'b1;
				hold_len = LONG_HOLD;
				open_len = 1;
			end else if (r < 10) begin
				hold_len = 0;
				open_len = $urandom_range(40, 150);
			end else if (r < 75) begin
				hold_len = $urandom_range(0, 2);
				open_len = $urandom_range(1, 6);
			end else if (r < 95) begin
				hold_len = $urandom_range(3, 10);
				open_len = $urandom_range(1, 4);
			end else begin
				hold_len = $urandom_range(20, 60);
				open_len = $urandom_range(1, 4);
			end
			if (hold_len > 0) begin
				res_stall <= 1'b1;
				repeat (hold_len) @(posedge clk);
			end
			res_stall <= 1'b0;
			repeat (open_len) @(posedge clk);
		end
	end

	// Byte side: build the stimulus, reset, then offer every byte in order
	initial begin : tx
		int unsigned i;
		int unsigned half;
		int unsigned gap;
		int unsigned r;
		bit          burst;
		burst = 1'b0;
		for (i = 0; i < DIR_N; i++)
			put(DIR_TAB[i].kind, DIR_TAB[i].ch);
		while (byte_q.size() < DIR_N + RAND_ITEMS)
			gen_reference();
		half = DIR_N + (byte_q.size() - DIR_N) / 2;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < byte_q.size(); i++) begin
			if (i % 64 == 0)
				burst = ($urandom_range(0, 3) == 0);
			// drain: hold off until every pending result has arrived
			if (i == DIR_N || i == half) begin
				byte_valid <= 1'b0;
				@(posedge clk);
				while (decode_q.size() != 0)
					@(posedge clk);
			end
			r = $urandom_range(0, 99);
			if (burst || r < 55)
				gap = 0;
			else if (r < 90)
				gap = $urandom_range(1, 3);
			else if (r < 98)
				gap = $urandom_range(4, 12);
			else
				gap = $urandom_range(20, 60);
			if (gap > 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			byte_valid <= 1'b1;
			byte_item  <= byte_q[i];
			do
				@(posedge clk);
			while (byte_stall);
		end
		byte_valid <= 1'b0;

		@(posedge clk);
		while (decode_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d byte transfers, checked %0d results: %0d determined, %0d saturated",
			byte_seen, res_seen, det_seen, sat_seen);
		$display("Covered numeric and named references, restarts, bad bytes, stalls; %0d mismatches",
			fail_cnt);
		if (fail_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
